// File: src/femap_pkg.sv
// Shared types, constants and codes for the file extent read mapper.
`timescale 1ns / 1ps
`default_nettype none
package femap_pkg;

	localparam int MAX_RUNS_DEF    = 56;
	localparam int SECTOR_BITS_DEF = 9;

	localparam int OFS_W    = 49;
	localparam int CNT_W    = 32;
	localparam int SEC32_W  = 32;
	localparam int RUNIDX_W = 6;
	localparam int NRUN_W   = 7;
	localparam int ALU_W    = OFS_W + 1;
	localparam int LARGE_SHIFT = 17;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_RUN_COUNT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FILE_SIZE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LARGE_UNITS = 2'd2;

	localparam logic CMD_WRITE_RUN = 1'b0;
	localparam logic CMD_READ      = 1'b1;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_SHORT    = 2'd1;
	localparam logic [1:0] ST_PAST_END = 2'd2;
	localparam logic [1:0] ST_INLINE   = 2'd3;

	typedef struct packed {
		logic                command;
		logic [RUNIDX_W-1:0] run_index;
		logic [SEC32_W-1:0]  run_start_sector;
		logic [SEC32_W-1:0]  run_sector_length;
		logic [OFS_W-1:0]    byte_offset;
		logic [CNT_W-1:0]    byte_count;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [SEC32_W-1:0] disk_sector;
		logic [SEC32_W-1:0] sector_count;
		logic [CNT_W-1:0]   chunk_bytes;
		logic               last;
	} res_t;

	// operation handed to the shared add/subtract unit
	typedef struct packed {
		logic             sub;
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
	} alu_op_t;

endpackage
`default_nettype wire

// File: src/femap_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module femap_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 56,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// File: src/femap_alu.sv
// Shared add/subtract unit with borrow out, used by the sequencer's arithmetic steps.
`timescale 1ns / 1ps
`default_nettype none
module femap_alu (
	input  wire femap_pkg::alu_op_t             op,
	output logic [femap_pkg::ALU_W-1:0]         res,
	output logic                                borrow
);

	logic [femap_pkg::ALU_W:0] wide;

	always_comb begin
		if (op.sub) begin
			wide = {1'b0, op.a} - {1'b0, op.b};
		end else begin
			wide = {1'b0, op.a} + {1'b0, op.b};
		end
		res    = wide[femap_pkg::ALU_W-1:0];
		borrow = op.sub & wide[femap_pkg::ALU_W];
	end

endmodule
`default_nettype wire

// File: src/file_extent_read_mapper_unit.sv
// Top level: run list store, read request sequencer and result register.
//
// Usage: load the run list with start/command=write beats (run_index, start
// sector, length); these leave the block idle and give no result. Set
// run_count, file_size and large_units through the cfg_we/cfg_index/cfg_data
// port while the block is idle. A read beat (start high, busy low) carries a
// byte offset and count; the block answers with one or more results, each
// shown for one cycle with result_valid high, the final one marked by last.
// Sequence: a read first checks the size and clamps the count, then for every
// chunk reads and compares run table entries until one holds the offset or the
// list ends, then does the chunk math on the shared adder. The scan resumes
// at the current entry for each new chunk. A chunk is held back until the
// next run lookup decides its status. busy stays high until the final result
// is shown; the next beat may be taken in that same cycle.
// The receiver cannot stall: results are never held off.
// Reset clears the configuration registers and the sequencer; the run table
// is not cleared and must be written before it is used.
`timescale 1ns / 1ps
`default_nettype none
module file_extent_read_mapper_unit #(
	parameter int MAX_RUNS    = femap_pkg::MAX_RUNS_DEF,
	parameter int SECTOR_BITS = femap_pkg::SECTOR_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire femap_pkg::req_t                 req,
	input  wire logic                            cfg_we,
	input  wire logic [femap_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [femap_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                                 result_valid,
	output femap_pkg::res_t                      result
);

	localparam int IDX_W  = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
	localparam int REL_W  = femap_pkg::OFS_W - SECTOR_BITS + 1;
	localparam int ALU_W  = femap_pkg::ALU_W;
	localparam int CNT_W  = femap_pkg::CNT_W;
	localparam int NRUN_W = femap_pkg::NRUN_W;
	localparam int S32_W  = femap_pkg::SEC32_W;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_SIZE  = 4'd1;
	localparam logic [3:0] S_CLAMP = 4'd2;
	localparam logic [3:0] S_RD    = 4'd3;
	localparam logic [3:0] S_CMP   = 4'd4;
	localparam logic [3:0] S_AVAIL = 4'd5;
	localparam logic [3:0] S_NSEC  = 4'd6;
	localparam logic [3:0] S_MIN   = 4'd7;
	localparam logic [3:0] S_BYTES = 4'd8;
	localparam logic [3:0] S_DISK  = 4'd9;
	localparam logic [3:0] S_ADV   = 4'd10;

	// configuration
	logic [5:0]       run_count_q;
	logic [S32_W-1:0] file_size_q;
	logic             large_q;

	// request state
	logic [3:0]                   state_q;
	logic [femap_pkg::OFS_W-1:0]  ofs_q;
	logic [CNT_W-1:0]             count_q;
	logic [ALU_W-1:0]             d_q;
	logic [NRUN_W-1:0]            nruns_q;
	logic [IDX_W-1:0]             idx_q;
	logic [REL_W-1:0]             rel_q;
	logic [S32_W-1:0]             avail_q;
	logic [S32_W-1:0]             n_q;
	logic [CNT_W-1:0]             n2_q;
	logic [S32_W-1:0]             disk_q;
	logic [NRUN_W-1:0]            k_q;
	femap_pkg::res_t              pend_q;
	logic                         pend_v_q;
	femap_pkg::res_t              res_q;
	logic                         res_v_q;

	// run table
	logic                    ram_we;
	logic [2*S32_W-1:0]      ram_rdata;
	logic [S32_W-1:0]        rd_start;
	logic [S32_W-1:0]        rd_len;

	// shared adder
	femap_pkg::alu_op_t      alu_op;
	logic [ALU_W-1:0]        alu_res;
	logic                    alu_borrow;

	logic                    accept;
	logic [NRUN_W-1:0]       nruns_in;
	logic [ALU_W-1:0]        size_sel;
	logic [CNT_W-1:0]        clamped;
	logic [NRUN_W-1:0]       k_next;
	logic [ALU_W-1:0]        n_bytes;

	assign busy         = (state_q != S_IDLE);
	assign accept       = start & ~busy;
	assign result_valid = res_v_q;
	assign result       = res_q;

	assign ram_we = accept && (req.command == femap_pkg::CMD_WRITE_RUN)
		&& (NRUN_W'(req.run_index) < NRUN_W'(MAX_RUNS));

	femap_ram #(
		.WIDTH (2 * S32_W),
		.DEPTH (MAX_RUNS)
	) u_runs (
		.clk   (clk),
		.we    (ram_we),
		.waddr (req.run_index[IDX_W-1:0]),
		.wdata ({req.run_start_sector, req.run_sector_length}),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	assign rd_start = ram_rdata[2*S32_W-1:S32_W];
	assign rd_len   = ram_rdata[S32_W-1:0];

	femap_alu u_alu (
		.op     (alu_op),
		.res    (alu_res),
		.borrow (alu_borrow)
	);

	assign nruns_in = (NRUN_W'(run_count_q) > NRUN_W'(MAX_RUNS)) ? NRUN_W'(MAX_RUNS)
		: NRUN_W'(run_count_q);
	assign size_sel = (nruns_q == '0) ? ALU_W'(file_size_q)
		: (large_q ? (ALU_W'(file_size_q) << femap_pkg::LARGE_SHIFT) : ALU_W'(file_size_q));
	assign clamped  = alu_borrow ? d_q[CNT_W-1:0] : count_q;
	assign k_next   = k_q + NRUN_W'(1);
	assign n_bytes  = ALU_W'(n_q) << SECTOR_BITS;

	// operand selection for the shared unit
	always_comb begin
		alu_op = '0;
		case (state_q)
			S_SIZE: begin
				alu_op = '{sub: 1'b1, a: size_sel, b: ALU_W'(ofs_q)};
			end
			S_CLAMP: begin
				alu_op = '{sub: 1'b1, a: d_q, b: ALU_W'(count_q)};
			end
			S_CMP: begin
				alu_op = '{sub: 1'b1, a: ALU_W'(rel_q), b: ALU_W'(rd_len)};
			end
			S_AVAIL: begin
				alu_op = '{sub: 1'b1, a: ALU_W'(rd_len), b: ALU_W'(rel_q[S32_W-1:0])};
			end
			S_NSEC: begin
				alu_op = '{sub: 1'b0, a: ALU_W'(count_q >> SECTOR_BITS),
					b: ALU_W'(|count_q[SECTOR_BITS-1:0])};
			end
			S_MIN: begin
				alu_op = '{sub: 1'b1, a: ALU_W'(avail_q), b: ALU_W'(n_q)};
			end
			S_BYTES: begin
				alu_op = '{sub: 1'b1, a: ALU_W'(count_q), b: n_bytes};
			end
			S_DISK: begin
				alu_op = '{sub: 1'b0, a: ALU_W'(rd_start), b: ALU_W'(rel_q[S32_W-1:0])};
			end
			S_ADV: begin
				alu_op = '{sub: 1'b0, a: ALU_W'(rel_q), b: ALU_W'(n_q)};
			end
			default: begin
				alu_op = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_count_q <= '0;
			file_size_q <= '0;
			large_q     <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				femap_pkg::REG_RUN_COUNT:   run_count_q <= cfg_data[5:0];
				femap_pkg::REG_FILE_SIZE:   file_size_q <= cfg_data[S32_W-1:0];
				femap_pkg::REG_LARGE_UNITS: large_q     <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				ofs_q   <= req.byte_offset;
				count_q <= req.byte_count;
				nruns_q <= nruns_in;
			end
			S_SIZE: begin
				d_q <= alu_res;
			end
			S_CLAMP: begin
				count_q <= clamped;
				rel_q   <= REL_W'(ofs_q >> SECTOR_BITS);
				idx_q   <= '0;
			end
			S_CMP: begin
				if (!alu_borrow) begin
					rel_q <= alu_res[REL_W-1:0];
					if (NRUN_W'(idx_q) + NRUN_W'(1) != nruns_q) begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
			end
			S_AVAIL: begin
				avail_q <= alu_res[S32_W-1:0];
			end
			S_NSEC: begin
				n_q <= alu_res[S32_W-1:0];
			end
			S_MIN: begin
				if (alu_borrow) begin
					n_q <= avail_q;
				end
			end
			S_BYTES: begin
				// short tail: the chunk takes what is left of the count
				if (alu_borrow) begin
					n2_q    <= count_q;
					count_q <= '0;
				end else begin
					n2_q    <= n_bytes[CNT_W-1:0];
					count_q <= alu_res[CNT_W-1:0];
				end
			end
			S_DISK: begin
				disk_q <= alu_res[S32_W-1:0];
			end
			S_ADV: begin
				rel_q  <= alu_res[REL_W-1:0];
				pend_q <= '{status: femap_pkg::ST_OK, disk_sector: disk_q,
					sector_count: n_q, chunk_bytes: n2_q, last: 1'b0};
			end
			default: begin
			end
		endcase
	end

	// sequencer and result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			res_v_q  <= 1'b0;
			res_q    <= '0;
			pend_v_q <= 1'b0;
			k_q      <= '0;
		end else begin
			res_v_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept && req.command == femap_pkg::CMD_READ) begin
						state_q <= S_SIZE;
					end
				end
				S_SIZE: begin
					if (alu_borrow || alu_res == '0) begin
						res_v_q <= 1'b1;
						res_q   <= '{status: femap_pkg::ST_PAST_END, disk_sector: '0,
							sector_count: '0, chunk_bytes: '0, last: 1'b1};
						state_q <= S_IDLE;
					end else begin
						state_q <= S_CLAMP;
					end
				end
				S_CLAMP: begin
					pend_v_q <= 1'b0;
					k_q      <= '0;
					if (nruns_q == '0) begin
						res_v_q <= 1'b1;
						res_q   <= '{status: femap_pkg::ST_INLINE, disk_sector: '0,
							sector_count: '0, chunk_bytes: clamped, last: 1'b1};
						state_q <= S_IDLE;
					end else if (clamped == '0) begin
						res_v_q <= 1'b1;
						res_q   <= '{status: femap_pkg::ST_OK, disk_sector: '0,
							sector_count: '0, chunk_bytes: '0, last: 1'b1};
						state_q <= S_IDLE;
					end else begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (alu_borrow) begin
						// next run found: the held chunk is not the last one
						if (pend_v_q) begin
							res_v_q  <= 1'b1;
							res_q    <= pend_q;
							pend_v_q <= 1'b0;
						end
						state_q <= S_AVAIL;
					end else if (NRUN_W'(idx_q) + NRUN_W'(1) == nruns_q) begin
						// ran off the end of the run list
						res_v_q <= 1'b1;
						if (pend_v_q) begin
							res_q <= '{status: femap_pkg::ST_SHORT,
								disk_sector: pend_q.disk_sector,
								sector_count: pend_q.sector_count,
								chunk_bytes: pend_q.chunk_bytes, last: 1'b1};
						end else begin
							res_q <= '{status: femap_pkg::ST_SHORT, disk_sector: '0,
								sector_count: '0, chunk_bytes: '0, last: 1'b1};
						end
						pend_v_q <= 1'b0;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_RD;
					end
				end
				S_AVAIL: state_q <= S_NSEC;
				S_NSEC:  state_q <= S_MIN;
				S_MIN:   state_q <= S_BYTES;
				S_BYTES: state_q <= S_DISK;
				S_DISK:  state_q <= S_ADV;
				S_ADV: begin
					k_q <= k_next;
					if (count_q == '0) begin
						res_v_q <= 1'b1;
						res_q   <= '{status: femap_pkg::ST_OK, disk_sector: disk_q,
							sector_count: n_q, chunk_bytes: n2_q, last: 1'b1};
						state_q <= S_IDLE;
					end else if (k_next >= NRUN_W'(MAX_RUNS)) begin
						res_v_q <= 1'b1;
						res_q   <= '{status: femap_pkg::ST_SHORT, disk_sector: disk_q,
							sector_count: n_q, chunk_bytes: n2_q, last: 1'b1};
						state_q <= S_IDLE;
					end else begin
						pend_v_q <= 1'b1;
						state_q  <= S_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// File: tb/femap_sb_pkg.sv
// Scoreboard class for the file extent read mapper: request prediction and result checks.
`timescale 1ns / 1ps
package femap_sb_pkg;
	import femap_pkg::*;

	localparam int TABLE_DEPTH = MAX_RUNS_DEF;

	class extent_scoreboard;
		bit [31:0] run_start [TABLE_DEPTH];
		bit [31:0] run_len [TABLE_DEPTH];
		bit [5:0]  run_count;
		bit [31:0] file_size;
		bit        large_units;
		res_t      chunk_q[$];
		int        errors;
		int        reads;
		int        table_writes;
		int        results_seen;
		int        status_hits[4];

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
			REG_RUN_COUNT: run_count = data[5:0];
			REG_FILE_SIZE: file_size = data;
			REG_LARGE_UNITS: large_units = data[0];
			default: ;
			endcase
		endfunction

		function res_t chunk(logic [1:0] st, logic [31:0] ds, logic [31:0] sc, logic [31:0] cb,
				logic lst);
			res_t r;
			r.status = st;
			r.disk_sector = ds;
			r.sector_count = sc;
			r.chunk_bytes = cb;
			r.last = lst;
			return r;
		endfunction

		// Called for every accepted beat, in acceptance order.
		function void note_request(req_t r);
			int unsigned nruns;
			int unsigned i;
			longint unsigned ofs, cnt, size, sec, base, n, n2, avail, ds;
			bit hit;
			res_t found[$];
			if (r.command == CMD_WRITE_RUN) begin
				table_writes++;
				if (r.run_index < TABLE_DEPTH) begin
					run_start[r.run_index] = r.run_start_sector;
					run_len[r.run_index] = r.run_sector_length;
				end
				return;
			end
			reads++;
			nruns = (run_count > TABLE_DEPTH) ? TABLE_DEPTH : run_count;
			ofs = r.byte_offset;
			cnt = r.byte_count;
			if (nruns == 0) begin
				// inline data, size never scaled
				if (ofs >= file_size) begin
					chunk_q.push_back(chunk(ST_PAST_END, 0, 0, 0, 1));
				end else begin
					if (cnt > file_size - ofs)
						cnt = file_size - ofs;
					chunk_q.push_back(chunk(ST_INLINE, 0, 0, 32'(cnt), 1));
				end
				return;
			end
			size = file_size;
			if (large_units)
				size = size << LARGE_SHIFT;
			if (ofs >= size) begin
				chunk_q.push_back(chunk(ST_PAST_END, 0, 0, 0, 1));
				return;
			end
			if (ofs + cnt > size)
				cnt = size - ofs;
			if (cnt == 0) begin
				chunk_q.push_back(chunk(ST_OK, 0, 0, 0, 1));
				return;
			end
			sec = ofs >> SECTOR_BITS_DEF;
			while (cnt > 0) begin
				base = 0;
				hit = 0;
				for (i = 0; i < nruns; i++) begin
					if (sec < base + run_len[i]) begin
						hit = 1;
						break;
					end
					base += run_len[i];
				end
				if (!hit || found.size() >= TABLE_DEPTH) begin
					// ran off the run list: mark the previous chunk short, or report alone
					if (found.size() == 0) begin
						found.push_back(chunk(ST_SHORT, 0, 0, 0, 1));
					end else begin
						found[found.size()-1].status = ST_SHORT;
						found[found.size()-1].last = 1'b1;
					end
					break;
				end
				n = (cnt + (64'd1 << SECTOR_BITS_DEF) - 1) >> SECTOR_BITS_DEF;
				avail = run_len[i] - (sec - base);
				if (n > avail)
					n = avail;
				n2 = n << SECTOR_BITS_DEF;
				if (n2 > cnt)
					n2 = cnt;
				cnt -= n2;
				ds = run_start[i] + (sec - base);
				found.push_back(chunk(ST_OK, 32'(ds), 32'(n), 32'(n2), cnt == 0));
				sec += n;
			end
			foreach (found[j])
				chunk_q.push_back(found[j]);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				errors++;
				if (errors <= 40)
					$display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
			end
		endfunction

		function void check_result(res_t got);
			res_t want;
			results_seen++;
			if (!$isunknown(got.status))
				status_hits[got.status]++;
			if (chunk_q.size() == 0) begin
				errors++;
				if (errors <= 40)
					$display("%0t: result with none expected, expected nothing, got %p", $time, got);
				return;
			end
			want = chunk_q.pop_front();
			compare_field("status", 32'(want.status), 32'(got.status));
			compare_field("disk_sector", want.disk_sector, got.disk_sector);
			compare_field("sector_count", want.sector_count, got.sector_count);
			compare_field("chunk_bytes", want.chunk_bytes, got.chunk_bytes);
			compare_field("last", 32'(want.last), 32'(got.last));
		endfunction
	endclass

endpackage

// File: tb/tb_top.sv
// Testbench top: drives table writes, reads and register writes into the extent read mapper.
`timescale 1ns / 1ps
module tb_top;
	import femap_pkg::*;
	import femap_sb_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int TAIL_CYCLES    = 600;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	req_t                  req = '0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  busy;
	logic                  result_valid;
	res_t                  result;

	extent_scoreboard sb;
	bit [31:0] len_copy [MAX_RUNS_DEF];
	bit        run_written [MAX_RUNS_DEF];
	int        sender_idle_pct;
	int        beats_sent;
	int        quiet_cycles;
	int        quota;

	always #10 clk = ~clk;

	file_extent_read_mapper_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req          (req),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result       (result)
	);

	// Results are checked before the beat taken at the same edge is predicted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid)
				sb.check_result(result);
			if (start && !busy)
				sb.note_request(req);
			if (cfg_we)
				sb.set_reg(cfg_index, cfg_data);
			if (result_valid || (start && !busy) || cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no beat or result for %0d cycles, %0d results outstanding",
					$time, WATCHDOG_LIMIT, sb.chunk_q.size());
				$display("file_extent_read_mapper_unit: mismatch");
				$finish;
			end
		end
	end

	function automatic longint unsigned rand_below(longint unsigned lim);
		longint unsigned r;
		r = {$urandom, $urandom};
		return (lim == 0) ? 0 : r % lim;
	endfunction

	function automatic bit [31:0] pick_len();
		case ($urandom_range(9))
		0: return 32'd0;
		1: return $urandom_range(9, 400);
		2: return $urandom;
		default: return $urandom_range(1, 8);
		endcase
	endfunction

	function automatic req_t table_beat(bit [5:0] idx, bit [31:0] first, bit [31:0] len);
		req_t r;
		r.command = CMD_WRITE_RUN;
		r.run_index = idx;
		r.run_start_sector = first;
		r.run_sector_length = len;
		r.byte_offset = 49'({$urandom, $urandom});
		r.byte_count = $urandom;
		return r;
	endfunction

	function automatic req_t read_beat(longint unsigned ofs, bit [31:0] cnt);
		req_t r;
		r.command = CMD_READ;
		r.run_index = 6'($urandom);
		r.run_start_sector = $urandom;
		r.run_sector_length = $urandom;
		r.byte_offset = 49'(ofs);
		r.byte_count = cnt;
		return r;
	endfunction

	// Entered and left at a falling edge; start stays high on return.
	task automatic send_item(input req_t item);
		start = 1'b1;
		req = item;
		do
			@(posedge clk);
		while (busy);
		beats_sent++;
		@(negedge clk);
	endtask

	task automatic sender_gap();
		while ($urandom_range(99) < sender_idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
	endtask

	task automatic write_run(bit [5:0] idx, bit [31:0] first, bit [31:0] len);
		sender_gap();
		send_item(table_beat(idx, first, len));
		if (idx < MAX_RUNS_DEF) begin
			len_copy[idx] = len;
			run_written[idx] = 1'b1;
		end
	endtask

	task automatic read_file(longint unsigned ofs, bit [31:0] cnt);
		sender_gap();
		send_item(read_beat(ofs, cnt));
	endtask

	// Hold off until every expected result is back and the block is idle.
	task automatic drain();
		start = 1'b0;
		do
			@(posedge clk);
		while (busy || sb.chunk_q.size() != 0);
		@(negedge clk);
	endtask

	task automatic set_config(bit [5:0] rc, bit [31:0] fs, bit lu);
		drain();
		repeat (8) @(negedge clk);
		cfg_we = 1'b1;
		cfg_index = REG_RUN_COUNT;
		cfg_data = 32'(rc);
		@(negedge clk);
		cfg_index = REG_FILE_SIZE;
		cfg_data = fs;
		@(negedge clk);
		cfg_index = REG_LARGE_UNITS;
		cfg_data = 32'(lu);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// forced_rc < 0 picks a random run count; otherwise that count with short runs
	task automatic random_segment(int forced_rc, int reads_wanted);
		bit [5:0]        rc;
		bit              lu;
		bit              forced;
		bit [31:0]       fs;
		bit [31:0]       cnt;
		int              eff;
		int              pick;
		int              idx;
		longint unsigned total, cap, tmp, size, ofs;
		forced = forced_rc >= 0;
		if (forced) begin
			rc = 6'(forced_rc);
		end else begin
			pick = $urandom_range(9);
			rc = (pick < 2) ? 6'd0 : (pick < 4) ? 6'd1 : 6'($urandom_range(2, 14));
		end
		eff = (rc > MAX_RUNS_DEF) ? MAX_RUNS_DEF : rc;
		// every entry the read can scan is written first
		for (int i = 0; i < eff; i++)
			if (!run_written[i] || $urandom_range(2) == 0)
				write_run(6'(i), $urandom, forced ? $urandom_range(1, 3) : pick_len());
		total = 0;
		for (int i = 0; i < eff; i++)
			total += len_copy[i];
		cap = total << SECTOR_BITS_DEF;
		if (cap > 64'hFFFF_FFFF)
			cap = 64'hFFFF_FFFF;
		lu = !forced && ($urandom_range(3) == 0);
		if (eff == 0) begin
			fs = $urandom_range(1) ? $urandom_range(0, 5000) : $urandom;
		end else if (lu) begin
			fs = ($urandom_range(5) == 0) ? $urandom : $urandom_range(0, 3);
		end else begin
			pick = forced ? 1 : $urandom_range(3);
			case (pick)
			0: fs = $urandom;
			1: begin
				tmp = cap + $urandom_range(0, 4096);
				fs = (tmp > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(tmp);
			end
			default: fs = 32'(rand_below(cap + 1));
			endcase
		end
		set_config(rc, fs, lu);
		size = fs;
		if (lu && eff != 0)
			size = size << LARGE_SHIFT;
		if (forced)
			read_file(0, 32'hFFFF_FFFF);
		for (int n = 0; n < reads_wanted; n++) begin
			if ($urandom_range(19) == 0)
				write_run(6'($urandom_range(56, 63)), $urandom, $urandom);
			if (eff > 0 && $urandom_range(19) == 0) begin
				idx = $urandom_range(0, eff - 1);
				write_run(6'(idx), $urandom, forced ? $urandom_range(1, 3) : pick_len());
				size = size;
			end
			if ($urandom_range(24) == 0)
				drain();
			case ($urandom_range(9))
			0: ofs = size + rand_below(4096);
			1: ofs = rand_below(64'd1 << OFS_W);
			2: ofs = rand_below(size);
			default: ofs = (rand_below(size) >> SECTOR_BITS_DEF) << SECTOR_BITS_DEF;
			endcase
			case ($urandom_range(9))
			0: cnt = 32'd0;
			1: cnt = $urandom;
			2: cnt = 32'hFFFF_FFFF;
			3, 4: cnt = $urandom_range(1, 600);
			default: cnt = $urandom_range(1, 16 << SECTOR_BITS_DEF);
			endcase
			read_file(ofs, cnt);
		end
	endtask

	initial begin
		sb = new();
		sender_idle_pct = 28;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// registers still at reset: inline, empty file
		read_file(0, 10);
		set_config(0, 1000, 0);
		read_file(0, 32'hFFFF_FFFF);
		read_file(512, 100);
		read_file(1000, 5);
		read_file(49'h1_FFFF_FFFF_FFFF, 0);

		write_run(0, 100, 4);
		write_run(1, 32'hFFFF_FFFE, 3);
		write_run(2, 5000, 0);
		write_run(3, 0, 32'hFFFF_FFFF);
		write_run(63, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		write_run(56, 32'h1234_5678, 1);

		set_config(3, 32'hFFFF_FFFF, 0);
		read_file(0, 32'hFFFF_FFFF);
		read_file(3584, 10);
		read_file(700, 1);
		read_file(512, 0);
		read_file(32'hFFFF_FFFF, 1);

		set_config(4, 1, 1);
		read_file(0, 32'hFFFF_FFFF);
		read_file(131072, 1);
		read_file(130000, 5000);

		// scaled size near 2^49: wide offsets and sector indexes
		set_config(4, 32'hFFFF_FFFF, 1);
		read_file(49'h1_0000_0000_0000, 32'h0000_1000);
		read_file(64'h1_0000_0005 << SECTOR_BITS_DEF, 2000);

		quota = beats_sent + 20;
		while (beats_sent < quota)
			random_segment(-1, $urandom_range(6, 14));

		sender_idle_pct = 83;
		quota = beats_sent + 20;
		while (beats_sent < quota)
			random_segment(-1, $urandom_range(6, 14));

		sender_idle_pct = 0;
		random_segment(63, 4);
		random_segment(56, 4);
		quota = beats_sent + 8;
		while (beats_sent < quota)
			random_segment(-1, $urandom_range(6, 14));

		drain();
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Covered %0d reads and %0d run table writes, %0d results checked.",
			sb.reads, sb.table_writes, sb.results_seen);
		$display("Status seen: ok %0d, short %0d, past end %0d, inline %0d.",
			sb.status_hits[ST_OK], sb.status_hits[ST_SHORT], sb.status_hits[ST_PAST_END],
			sb.status_hits[ST_INLINE]);
		if (sb.errors == 0 && sb.chunk_q.size() == 0) begin
			$display("file_extent_read_mapper_unit: match");
		end else begin
			$display("file_extent_read_mapper_unit: mismatch");
		end
		$finish;
	end

endmodule
